@@ sv/spbf_pkg.sv @@
// Shared types and constants for the spectrum peak bin finder.
`default_nettype none

package spbf_pkg;

    localparam int FRAME_POINTS_DEF = 1024;

    localparam int BIN_W      = 16;
    localparam int IDX_W      = 9;
    localparam int FREQ_W     = 15;
    localparam int PRE_W      = 7;
    localparam int SQ_W       = 31;
    localparam int MAG_W      = 32;
    localparam int FREQ_SCALE = 36;
    localparam int PRE_RESET  = 36;
    localparam int DIV_STEPS  = FREQ_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic signed [BIN_W-1:0] bin_real;
        logic signed [BIN_W-1:0] bin_imag;
        logic                    last_bin;
    } t_bin_in;

    typedef struct packed {
        logic [IDX_W-1:0]  peak_bin;
        logic [FREQ_W-1:0] peak_frequency;
    } t_peak_out;

    // controller -> datapath commands
    typedef struct packed {
        logic bin_take;
        logic load;
        logic div_step;
        logic cfg_we;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ sv/spbf_ctrl.sv @@
// Sequencer for the peak bin finder: bin intake, end-of-frame divide, result strobe.
`default_nettype none

module spbf_ctrl
    import spbf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_last,
    input  wire logic    i_cfg_valid,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_cfg_ready,
    output logic         o_done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FLUSH = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_start && i_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: n_state = S_LOAD;
            S_LOAD: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        o_busy          = (r_state != S_IDLE);
        o_cfg_ready     = (r_state == S_IDLE);
        o_done          = (r_state == S_DONE);
        o_cmd.bin_take  = (r_state == S_IDLE) && i_start;
        o_cmd.load      = (r_state == S_LOAD);
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.cfg_we    = (r_state == S_IDLE) && i_cfg_valid;
    end

endmodule

`default_nettype wire

@@ sv/spbf_dp.sv @@
// Datapath: bin counter, magnitude pipe, running peak, prescaler and shift divider.
`default_nettype none

module spbf_dp
    import spbf_pkg::*;
#(
    parameter int FRAME_POINTS = FRAME_POINTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire t_bin_in          i_bin,
    input  wire logic [PRE_W-1:0] i_cfg_data,
    output t_peak_out             o_peak
);

    localparam int CNT_W = $clog2(FRAME_POINTS + 1);
    localparam int HALF  = FRAME_POINTS / 2;

    logic [CNT_W-1:0]  r_cnt;
    logic              r_s1_valid;
    logic [SQ_W-1:0]   r_sq_re, r_sq_im;
    logic [IDX_W-1:0]  r_s1_idx;
    logic [MAG_W-1:0]  r_best_mag;
    logic [IDX_W-1:0]  r_best_idx;
    logic [PRE_W-1:0]  r_pre;
    logic [PRE_W-1:0]  r_div;
    logic [PRE_W-1:0]  r_rem;
    logic [FREQ_W-1:0] r_dvd;
    logic [IDX_W-1:0]  r_peak_bin;

    logic                      w_in_win;
    logic signed [2*BIN_W-1:0] w_pr_re, w_pr_im;
    logic [MAG_W-1:0]          w_mag;
    logic [PRE_W:0]            w_rem_sh;
    logic                      w_ge;

    assign w_in_win = (r_cnt >= CNT_W'(1)) && (r_cnt < CNT_W'(HALF));
    assign w_pr_re  = i_bin.bin_real * i_bin.bin_real;
    assign w_pr_im  = i_bin.bin_imag * i_bin.bin_imag;
    assign w_mag    = {1'b0, r_sq_re} + {1'b0, r_sq_im};
    assign w_rem_sh = {r_rem, r_dvd[FREQ_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_div});

    // frame counter, saturates at the frame length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.bin_take) begin
            if (i_bin.last_bin) begin
                r_cnt <= '0;
            end else if (r_cnt != CNT_W'(FRAME_POINTS)) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // stage 1: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.bin_take && w_in_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bin_take) begin
            r_sq_re  <= w_pr_re[SQ_W-1:0];
            r_sq_im  <= w_pr_im[SQ_W-1:0];
            r_s1_idx <= IDX_W'(r_cnt);
        end
    end

    // stage 2: sum and compare, strictly larger wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_mag <= '0;
            r_best_idx <= '0;
        end else if (i_cmd.load) begin
            r_best_mag <= '0;
            r_best_idx <= '0;
        end else if (r_s1_valid && (w_mag > r_best_mag)) begin
            r_best_mag <= w_mag;
            r_best_idx <= r_s1_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre <= PRE_W'(PRE_RESET);
        end else if (i_cmd.cfg_we) begin
            r_pre <= i_cfg_data;
        end
    end

    // restoring divider, one quotient bit per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dvd      <= FREQ_W'(r_best_idx) * FREQ_W'(FREQ_SCALE);
            r_rem      <= '0;
            r_div      <= (r_pre == '0) ? PRE_W'(1) : r_pre;
            r_peak_bin <= r_best_idx;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[FREQ_W-2:0], w_ge};
            r_rem <= w_ge ? PRE_W'(w_rem_sh - {1'b0, r_div}) : PRE_W'(w_rem_sh);
        end
    end

    always_comb begin
        o_peak.peak_bin       = r_peak_bin;
        o_peak.peak_frequency = r_dvd;
    end

endmodule

`default_nettype wire

@@ sv/spectrum_peak_bin_finder.sv @@
// Top level of the spectrum peak bin finder: controller plus datapath.
// Bins are taken one per cycle; busy stays low through the body of a frame.
// The last bin of a frame raises busy through a flush state that finishes its compare,
// then the divider load, the bit-serial divide and the result strobe.
// o_done pulses for one cycle.
// Synchronous active-low reset clears counter, peak and state; prescaler goes to 36.
`default_nettype none

module spectrum_peak_bin_finder
    import spbf_pkg::*;
#(
    parameter int FRAME_POINTS = FRAME_POINTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // bin channel: transaction when start is high and busy is low
    input  wire logic             start,
    output logic                  busy,
    input  wire t_bin_in          i_bin,
    // result: valid for exactly the cycle o_done is high, no back-pressure
    output logic                  o_done,
    output t_peak_out             o_peak,
    // prescaler write channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [PRE_W-1:0] i_cfg_data
);

    t_dp_cmd w_cmd;

    // controller owns sequencing: which cycle takes a bin, loads or steps the divider
    spbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_last      (i_bin.last_bin),
        .i_cfg_valid (i_cfg_valid),
        .o_cmd       (w_cmd),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_done      (o_done)
    );

    // datapath: window check, squared magnitude (two stages), peak hold, divider
    spbf_dp #(
        .FRAME_POINTS (FRAME_POINTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_bin      (i_bin),
        .i_cfg_data (i_cfg_data),
        .o_peak     (o_peak)
    );

endmodule

`default_nettype wire
